>>> rtl/fbpa_pkg.sv
// Shared types, codes and constants of the fixed block pool allocator.
`timescale 1ns / 1ps

package fbpa_pkg;

    localparam int POOL_DEPTH_DEFAULT = 64;
    localparam int HANDLE_W           = 6;
    localparam int COUNT_W            = 7;
    localparam int RAM_WIDTH_DEFAULT  = 6;

    localparam logic [COUNT_W-1:0] POOL_ENTRIES_RESET = 7'd64;

    typedef enum logic
    {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        STATUS_OK            = 2'd0,
        STATUS_EXHAUSTED     = 2'd1,
        STATUS_NOT_ALLOCATED = 2'd2
    } status_t;

    typedef struct packed
    {
        op_t                 operation;
        logic [HANDLE_W-1:0] handle;
    } req_t;

    typedef struct packed
    {
        status_t             status;
        logic [HANDLE_W-1:0] granted_handle;
        logic [COUNT_W-1:0]  blocks_in_use;
    } rsp_t;

endpackage

>>> rtl/fixed_block_pool_allocator_core.sv
// Top level of the fixed block pool allocator: sequencer around two state RAMs.
`timescale 1ns / 1ps

// Usage
//   req channel (req_valid/req_ready/req): one beat per operation, allocate or
//   free a handle. rsp channel (rsp_valid/rsp_ready/rsp): one beat per request
//   with status, granted handle and the count of blocks in use afterwards.
//   cfg channel (cfg_valid/cfg_ready/cfg_data): writes the pool size; always
//   ready, write it only while no request is in flight.
// Timing
//   An allocate or a failed free reaches the result register from S_EXEC, the
//   state after acceptance; a successful free passes through S_EXEC and S_FIN,
//   since both the slot order RAM and the handle position RAM need two
//   write-backs through their single write port. One request is in flight at a
//   time; the next is accepted the cycle after the result is registered.
// Reset
//   The count clears and a clearing pass loads entry i of both RAMs with i;
//   req_ready stays low during the pass.
// Stall
//   A registered result waits for rsp_ready; a new request is still taken,
//   and its result is held back in the sequencer until the register frees.
module fixed_block_pool_allocator_core #(
    parameter int POOL_DEPTH = fbpa_pkg::POOL_DEPTH_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 req_valid,
    output logic                                 req_ready,
    input  fbpa_pkg::req_t                       req,
    output logic                                 rsp_valid,
    input  logic                                 rsp_ready,
    output fbpa_pkg::rsp_t                       rsp,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [fbpa_pkg::COUNT_W-1:0]         cfg_data
);

    localparam int IDX_W = $clog2(POOL_DEPTH);
    localparam int CNT_W = $clog2(POOL_DEPTH + 1);

    typedef enum logic [3:0]
    {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_EXEC  = 4'b0100,
        S_FIN   = 4'b1000
    } state_t;

    state_t                             state_reg, state_next;
    logic [CNT_W-1:0]                   count_reg, count_next;
    logic [IDX_W-1:0]                   clr_reg, clr_next;
    logic [fbpa_pkg::COUNT_W-1:0]       pool_entries_reg, pool_entries_next;
    logic                               out_valid_reg, out_valid_next;
    fbpa_pkg::rsp_t                     rsp_reg, rsp_next;
    fbpa_pkg::op_t                      op_reg, op_next;
    logic [fbpa_pkg::HANDLE_W-1:0]      handle_reg, handle_next;

    logic                               so_we, hp_we, rd_en;
    logic [IDX_W-1:0]                   so_waddr, so_wdata, so_raddr, so_rdata;
    logic [IDX_W-1:0]                   hp_waddr, hp_wdata, hp_raddr, hp_rdata;

    logic                               accept, out_free;
    logic                               alloc_ok, free_ok, handle_ok;
    logic [CNT_W-1:0]                   last;
    logic [IDX_W-1:0]                   last_idx, handle_idx;

    fbpa_ram #(
        .DEPTH (POOL_DEPTH),
        .WIDTH (IDX_W)
    ) u_slot_order (
        .clk   (clk),
        .we    (so_we),
        .waddr (so_waddr),
        .wdata (so_wdata),
        .re    (rd_en),
        .raddr (so_raddr),
        .rdata (so_rdata)
    );

    fbpa_ram #(
        .DEPTH (POOL_DEPTH),
        .WIDTH (IDX_W)
    ) u_handle_position (
        .clk   (clk),
        .we    (hp_we),
        .waddr (hp_waddr),
        .wdata (hp_wdata),
        .re    (rd_en),
        .raddr (hp_raddr),
        .rdata (hp_rdata)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign cfg_ready = 1'b1;
    assign rsp_valid = out_valid_reg;
    assign rsp       = rsp_reg;
    assign out_free  = !out_valid_reg || rsp_ready;

    // Issue both reads at acceptance: position of the handle, and the slot at
    // the count (allocate) or the last allocated slot (free)
    assign rd_en      = accept;
    assign hp_raddr   = IDX_W'(req.handle);
    assign so_raddr   = (req.operation == fbpa_pkg::OP_FREE) ? IDX_W'(count_reg - 1'b1)
                                                             : IDX_W'(count_reg);

    // Decode the operation against the values read back
    assign last       = count_reg - 1'b1;
    assign last_idx   = IDX_W'(last);
    assign handle_idx = IDX_W'(handle_reg);
    assign handle_ok  = 32'(handle_reg) < 32'(POOL_DEPTH);
    assign free_ok    = handle_ok && (32'(hp_rdata) < 32'(count_reg));
    assign alloc_ok   = (32'(count_reg) < 32'(pool_entries_reg))
                     && (32'(count_reg) < 32'(POOL_DEPTH));

    // Sequence clearing pass, operations and write-backs
    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        clr_next          = clr_reg;
        pool_entries_next = pool_entries_reg;
        out_valid_next    = out_valid_reg && !rsp_ready;
        rsp_next          = rsp_reg;
        op_next           = op_reg;
        handle_next       = handle_reg;
        so_we             = 1'b0;
        so_waddr          = clr_reg;
        so_wdata          = clr_reg;
        hp_we             = 1'b0;
        hp_waddr          = clr_reg;
        hp_wdata          = clr_reg;

        if (cfg_valid && cfg_ready)
        begin
            pool_entries_next = cfg_data;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                so_we    = 1'b1;
                hp_we    = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == POOL_DEPTH - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = req.operation;
                    handle_next = req.handle;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    if (op_reg == fbpa_pkg::OP_ALLOC)
                    begin
                        state_next     = S_IDLE;
                        out_valid_next = 1'b1;
                        if (alloc_ok)
                        begin
                            hp_we      = 1'b1;
                            hp_waddr   = so_rdata;
                            hp_wdata   = IDX_W'(count_reg);
                            count_next = count_reg + 1'b1;
                            rsp_next.status         = fbpa_pkg::STATUS_OK;
                            rsp_next.granted_handle = fbpa_pkg::HANDLE_W'(so_rdata);
                            rsp_next.blocks_in_use  =
                                fbpa_pkg::COUNT_W'(count_reg + 1'b1);
                        end
                        else
                        begin
                            rsp_next.status         = fbpa_pkg::STATUS_EXHAUSTED;
                            rsp_next.granted_handle = '0;
                            rsp_next.blocks_in_use  = fbpa_pkg::COUNT_W'(count_reg);
                        end
                    end
                    else if (free_ok)
                    begin
                        // Move the last allocated handle into the freed slot
                        so_we      = 1'b1;
                        so_waddr   = hp_rdata;
                        so_wdata   = so_rdata;
                        hp_we      = 1'b1;
                        hp_waddr   = so_rdata;
                        hp_wdata   = hp_rdata;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next              = S_IDLE;
                        out_valid_next          = 1'b1;
                        rsp_next.status         = fbpa_pkg::STATUS_NOT_ALLOCATED;
                        rsp_next.granted_handle = '0;
                        rsp_next.blocks_in_use  = fbpa_pkg::COUNT_W'(count_reg);
                    end
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    // Park the freed handle in the last allocated slot
                    so_we                   = 1'b1;
                    so_waddr                = last_idx;
                    so_wdata                = handle_idx;
                    hp_we                   = 1'b1;
                    hp_waddr                = handle_idx;
                    hp_wdata                = last_idx;
                    count_next              = last;
                    state_next              = S_IDLE;
                    out_valid_next          = 1'b1;
                    rsp_next.status         = fbpa_pkg::STATUS_OK;
                    rsp_next.granted_handle = '0;
                    rsp_next.blocks_in_use  = fbpa_pkg::COUNT_W'(last);
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            count_reg        <= '0;
            clr_reg          <= '0;
            pool_entries_reg <= fbpa_pkg::POOL_ENTRIES_RESET;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            clr_reg          <= clr_next;
            pool_entries_reg <= pool_entries_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        rsp_reg    <= rsp_next;
        op_reg     <= op_next;
        handle_reg <= handle_next;
    end

endmodule

>>> rtl/fbpa_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module fbpa_ram #(
    parameter int DEPTH = fbpa_pkg::POOL_DEPTH_DEFAULT,
    parameter int WIDTH = fbpa_pkg::RAM_WIDTH_DEFAULT
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Register read data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
